FILE: src/blzod_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blzod_pkg
// Constants of the backward LZ overlay token format.
// ----------------------------------------------------------------------------
package blzod_pkg;

	localparam int unsigned DIST_W       = 13;
	localparam int unsigned CNT_W        = 5;
	localparam int unsigned TOK_W        = 4;

	localparam logic [DIST_W-1:0] DIST_BIAS   = 13'd3;
	localparam logic [CNT_W-1:0]  CNT_BIAS    = 5'd3;
	localparam logic [TOK_W-1:0]  TOKENS_FLAG = 4'd8;
	localparam logic [CNT_W-1:0]  CNT_ONE     = 5'd1;

endpackage

FILE: src/blzod_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blzod_ram
// Simple dual-port RAM, one write port and one read port with registered read.
// ----------------------------------------------------------------------------
module blzod_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/backward_lz_overlay_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backward_lz_overlay_decoder
// Backward LZ77 decoder: flag bytes, literals and byte-pair back-references,
// emitted in reverse order through a history RAM.
// ----------------------------------------------------------------------------
// a literal waits in lit_q, then goes to the output register once it is free
// each copy byte is a history read (ST_READ), then write and load (ST_EMIT)
// flag and high bytes are taken in ST_IDLE; literals and copies hold off input
// the next input beat is taken the cycle after the last byte is loaded
// reset clears the token state, write position and output valid
// the history RAM is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
module backward_lz_overlay_decoder #(
	parameter int unsigned HISTORY_DEPTH = 8192
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       stream_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last
);

	import blzod_pkg::*;

	localparam int unsigned AW = $clog2(HISTORY_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_TOKEN,
		PH_LOW
	} phase_t;

	state_t            state_q;
	phase_t            phase_q;
	logic [7:0]        flag_q;
	logic [TOK_W-1:0]  tokens_q;
	logic [7:0]        high_q;
	logic [AW-1:0]     wp_q;
	logic [AW-1:0]     src_q;
	logic [CNT_W-1:0]  count_q;
	logic              is_lit_q;
	logic [7:0]        lit_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;

	logic              accept;
	logic              slot_free;
	logic              ram_we;
	logic              ram_re;
	logic [7:0]        ram_rdata;
	logic [7:0]        emit_byte;
	logic [DIST_W-1:0] back_dist;
	logic [AW:0]       diff;
	logic [AW-1:0]     src_start;
	logic [TOK_W-1:0]  tokens_dec;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign ram_we    = (state_q == ST_EMIT) && slot_free;
	assign ram_re    = (state_q == ST_READ);
	assign emit_byte = is_lit_q ? lit_q : ram_rdata;

	assign back_dist  = {1'b0, high_q[3:0], in_byte} + DIST_BIAS;
	assign diff       = {1'b0, wp_q} - (AW+1)'(back_dist);
	assign src_start  = diff[AW] ? AW'(diff + (AW+1)'(HISTORY_DEPTH)) : diff[AW-1:0];
	assign tokens_dec = (tokens_q != '0) ? tokens_q - TOK_W'(1) : tokens_q;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] v);
		return (v == AW'(HISTORY_DEPTH - 1)) ? '0 : v + AW'(1);
	endfunction

	blzod_ram #(
		.WIDTH(8),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(emit_byte),
		.re   (ram_re),
		.raddr(src_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_FLAG;
			flag_q      <= '0;
			tokens_q    <= '0;
			high_q      <= '0;
			wp_q        <= '0;
			src_q       <= '0;
			count_q     <= '0;
			is_lit_q    <= 1'b0;
			lit_q       <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !ram_we) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						priority if (phase_q == PH_TOKEN && tokens_q != '0) begin
							if (!flag_q[7]) begin
								lit_q    <= in_byte;
								is_lit_q <= 1'b1;
								count_q  <= CNT_ONE;
								state_q  <= ST_EMIT;
								flag_q   <= stream_end ? '0 : {flag_q[6:0], 1'b0};
								tokens_q <= stream_end ? '0 : tokens_dec;
								phase_q  <= (stream_end || tokens_dec == '0) ? PH_FLAG : PH_TOKEN;
							end else begin
								high_q  <= stream_end ? '0 : in_byte;
								phase_q <= stream_end ? PH_FLAG : PH_LOW;
								if (stream_end) begin
									flag_q   <= '0;
									tokens_q <= '0;
								end
							end
						end else if (phase_q == PH_LOW) begin
							src_q    <= src_start;
							count_q  <= CNT_W'(high_q[7:4]) + CNT_BIAS;
							is_lit_q <= 1'b0;
							state_q  <= ST_READ;
							flag_q   <= stream_end ? '0 : {flag_q[6:0], 1'b0};
							tokens_q <= stream_end ? '0 : tokens_dec;
							phase_q  <= (stream_end || tokens_dec == '0) ? PH_FLAG : PH_TOKEN;
						end else begin
							flag_q   <= stream_end ? '0 : in_byte;
							tokens_q <= stream_end ? '0 : TOKENS_FLAG;
							phase_q  <= stream_end ? PH_FLAG : PH_TOKEN;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= emit_byte;
						out_last_q  <= (count_q == CNT_ONE);
						wp_q        <= wrap_inc(wp_q);
						src_q       <= wrap_inc(src_q);
						count_q     <= count_q - CNT_ONE;
						state_q     <= (count_q == CNT_ONE) ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = out_last_q;

	// a run in flight always has bytes left
	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (count_q != '0))
		else $error("sequencer busy with no bytes left");

	// last byte of a run returns the sequencer to input
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && count_q == CNT_ONE) |=> (in_ready && out_valid && run_last))
		else $error("last byte did not end the run");

	// write position moves only with a history write
	a_wp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ram_we |=> $stable(wp_q))
		else $error("write position moved without a write");

	// at most eight tokens per flag byte
	a_tokens_max: assert property (@(posedge clk) disable iff (!arst_n)
		tokens_q <= TOKENS_FLAG)
		else $error("token count above eight");

endmodule
